// ----- design/cct_pkg.sv -----
`timescale 1ns / 1ps

package cct_pkg;

    typedef enum logic [2:0] {
        MODE_PASS      = 3'd0,
        MODE_ENC_KOI8R = 3'd1,
        MODE_ENC_CP866 = 3'd2,
        MODE_TRANSLIT  = 3'd3,
        MODE_DEC_KOI8R = 3'd4,
        MODE_FF_TO_DF  = 3'd5,
        MODE_DEC_CP866 = 3'd6,
        MODE_FF_DOUBLE = 3'd7
    } mode_t;

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_DF  = 8'hDF;
    localparam logic [7:0] LETTER_A = 8'h61;
    localparam logic [7:0] LETTER_C = 8'h63;
    localparam logic [7:0] LETTER_H = 8'h68;
    localparam logic [7:0] LETTER_U = 8'h75;

    // One converted run of up to three bytes; last_idx is the index of its final byte.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] last_idx;
    } seq_t;

    localparam logic [7:0] ENC_KOI8R [0:127] = '{
        8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,
        8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,
        8'h90,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,
        8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h9e,8'h9f,
        8'h9a,8'ha1,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
        8'hb3,8'hbf,8'haa,8'hab,8'hac,8'had,8'hae,8'haf,
        8'h9c,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'h9e,
        8'ha3,8'hb9,8'hba,8'hbb,8'hbc,8'hbd,8'hbe,8'hbf,
        8'he1,8'he2,8'hf7,8'he7,8'he4,8'he5,8'hf6,8'hfa,
        8'he9,8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,8'hf0,
        8'hf2,8'hf3,8'hf4,8'hf5,8'he6,8'he8,8'he3,8'hfe,
        8'hfb,8'hfd,8'hff,8'hf9,8'hf8,8'hfc,8'he0,8'hf1,
        8'hc1,8'hc2,8'hd7,8'hc7,8'hc4,8'hc5,8'hd6,8'hda,
        8'hc9,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hd0,
        8'hd2,8'hd3,8'hd4,8'hd5,8'hc6,8'hc8,8'hc3,8'hde,
        8'hdb,8'hdd,8'hdf,8'hd9,8'hd8,8'hdc,8'hc0,8'hf1
    };

    localparam logic [7:0] DEC_KOI8R [0:127] = '{
        8'd128,8'd129,8'd130,8'd131,8'd132,8'd133,8'd134,8'd135,
        8'd136,8'd137,8'd138,8'd139,8'd140,8'd141,8'd142,8'd143,
        8'd144,8'd145,8'd146,8'd147,8'd148,8'd149,8'd150,8'd151,
        8'd152,8'd153,8'd154,8'd155,8'd156,8'd157,8'd158,8'd159,
        8'd160,8'd161,8'd162,8'd168,8'd186,8'd165,8'd179,8'd191,
        8'd168,8'd169,8'd170,8'd171,8'd172,8'd173,8'd174,8'd175,
        8'd176,8'd177,8'd178,8'd168,8'd170,8'd181,8'd178,8'd175,
        8'd184,8'd185,8'd186,8'd187,8'd188,8'd189,8'd190,8'd191,
        8'd254,8'd224,8'd225,8'd246,8'd228,8'd229,8'd244,8'd227,
        8'd245,8'd232,8'd233,8'd234,8'd235,8'd236,8'd237,8'd238,
        8'd239,8'd223,8'd240,8'd241,8'd242,8'd243,8'd230,8'd226,
        8'd252,8'd251,8'd231,8'd248,8'd253,8'd249,8'd247,8'd250,
        8'd222,8'd192,8'd193,8'd214,8'd196,8'd197,8'd212,8'd195,
        8'd213,8'd200,8'd201,8'd202,8'd203,8'd204,8'd205,8'd206,
        8'd207,8'd223,8'd208,8'd209,8'd210,8'd211,8'd198,8'd194,
        8'd220,8'd219,8'd199,8'd216,8'd221,8'd217,8'd215,8'd218
    };

    localparam logic [7:0] ENC_CP866 [0:63] = '{
        8'd128,8'd129,8'd130,8'd131,8'd132,8'd133,8'd134,8'd135,
        8'd136,8'd137,8'd138,8'd139,8'd140,8'd141,8'd142,8'd143,
        8'd144,8'd145,8'd146,8'd147,8'd148,8'd149,8'd150,8'd151,
        8'd152,8'd153,8'd154,8'd155,8'd156,8'd157,8'd158,8'd159,
        8'd160,8'd161,8'd162,8'd163,8'd164,8'd165,8'd166,8'd167,
        8'd168,8'd169,8'd170,8'd171,8'd172,8'd173,8'd174,8'd175,
        8'd224,8'd225,8'd226,8'd227,8'd228,8'd229,8'd230,8'd231,
        8'd232,8'd233,8'd234,8'd235,8'd236,8'd237,8'd238,8'd239
    };

    localparam logic [7:0] DEC_CP866 [0:127] = '{
        8'hc0,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,
        8'hc8,8'hc9,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,
        8'hd0,8'hd1,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,
        8'hd8,8'hd9,8'hda,8'hdb,8'hdc,8'hdd,8'hde,8'hdf,
        8'he0,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,
        8'he8,8'he9,8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,
        8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,
        8'hb8,8'hb9,8'hba,8'hbb,8'hbc,8'hbd,8'hbe,8'hbf,
        8'hc0,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,
        8'hc8,8'hc9,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,
        8'hd0,8'hd1,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,
        8'hd8,8'hd9,8'hda,8'hdb,8'hdc,8'hdd,8'hde,8'hdf,
        8'hf0,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,
        8'hf8,8'hf9,8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'h9f,
        8'hf0,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,
        8'hf8,8'hf9,8'hfa,8'hfb,8'hfc,8'hfd,8'hfe,8'hcf
    };

    localparam logic [7:0] TRANSLIT_BASE [0:63] = '{
        8'h41,8'h42,8'h56,8'h47,8'h44,8'h45,8'h5a,8'h5a,
        8'h49,8'h59,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,8'h50,
        8'h52,8'h53,8'h54,8'h55,8'h46,8'h48,8'h43,8'h43,
        8'h53,8'h53,8'h27,8'h59,8'h27,8'h45,8'h59,8'h59,
        8'h61,8'h62,8'h76,8'h67,8'h64,8'h65,8'h7a,8'h7a,
        8'h69,8'h79,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,
        8'h72,8'h73,8'h74,8'h75,8'h66,8'h68,8'h63,8'h63,
        8'h73,8'h73,8'h27,8'h79,8'h27,8'h65,8'h79,8'h79
    };

endpackage

// ----- design/cct_if.sv -----
`timescale 1ns / 1ps

interface cct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface cct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- design/cyrillic_charset_transcoder.sv -----
`timescale 1ns / 1ps

// Converts a byte stream between CP1251, KOI8-R, CP866 and Latin transliteration, or handles
// the telnet byte 0xFF, as selected by the 3-bit mode written through cfg_we and cfg_wdata
// (write it only while no request is in flight). Each request on raw yields one to three
// bytes on coded, with last_of_run set on the final one. A request is registered, looked up
// in constant tables and placed in the output run register, so the block takes one byte per
// cycle while coded is ready and each run is one byte; a longer run holds the output register
// until its last byte is taken, which slows intake only in transliteration and doubling modes.
module cyrillic_charset_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    cct_in_if.sink      raw,
    cct_out_if.source   coded,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata
);

    cct_pkg::mode_t mode_reg;
    logic           raw_vld_reg;
    logic [7:0]     raw_byte_reg;
    cct_pkg::seq_t  seq;
    logic           take;

    assign raw.ready = !raw_vld_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= cct_pkg::MODE_PASS;
            raw_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cct_pkg::mode_t'(cfg_wdata);
            end
            if (raw.valid && raw.ready)
            begin
                raw_vld_reg <= 1'b1;
            end
            else if (take)
            begin
                raw_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            raw_byte_reg <= raw.in_byte;
        end
    end

    cct_map u_map (
        .byte_val (raw_byte_reg),
        .mode     (mode_reg),
        .seq      (seq)
    );

    cct_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .seq       (seq),
        .seq_valid (raw_vld_reg),
        .take      (take),
        .coded     (coded)
    );

endmodule

// ----- design/cct_map.sv -----
`timescale 1ns / 1ps

module cct_map (
    input  logic [7:0]          byte_val,
    input  cct_pkg::mode_t      mode,
    output cct_pkg::seq_t       seq
);

    always_comb
    begin
        seq.b0       = byte_val;
        seq.b1       = cct_pkg::BYTE_FF;
        seq.b2       = cct_pkg::LETTER_H;
        seq.last_idx = 2'd0;
        case (mode)
            cct_pkg::MODE_PASS:
            begin
            end
            cct_pkg::MODE_ENC_KOI8R:
            begin
                if (byte_val[7])
                begin
                    seq.b0 = cct_pkg::ENC_KOI8R[byte_val[6:0]];
                end
            end
            cct_pkg::MODE_ENC_CP866:
            begin
                if (byte_val[7:6] == 2'b11)
                begin
                    seq.b0 = cct_pkg::ENC_CP866[byte_val[5:0]];
                end
            end
            cct_pkg::MODE_TRANSLIT:
            begin
                if (byte_val[7:6] == 2'b11)
                begin
                    seq.b0 = cct_pkg::TRANSLIT_BASE[byte_val[5:0]];
                    if (byte_val inside {8'd198, 8'd215, 8'd216, 8'd230, 8'd247, 8'd248})
                    begin
                        seq.b1       = cct_pkg::LETTER_H;
                        seq.last_idx = 2'd1;
                    end
                    else if (byte_val inside {8'd217, 8'd249})
                    begin
                        seq.b1       = cct_pkg::LETTER_C;
                        seq.b2       = cct_pkg::LETTER_H;
                        seq.last_idx = 2'd2;
                    end
                    else if (byte_val inside {8'd222, 8'd254})
                    begin
                        seq.b1       = cct_pkg::LETTER_U;
                        seq.last_idx = 2'd1;
                    end
                    else if (byte_val inside {8'd223, 8'd255})
                    begin
                        seq.b1       = cct_pkg::LETTER_A;
                        seq.last_idx = 2'd1;
                    end
                end
            end
            cct_pkg::MODE_DEC_KOI8R:
            begin
                if (byte_val[7])
                begin
                    seq.b0 = cct_pkg::DEC_KOI8R[byte_val[6:0]];
                end
            end
            cct_pkg::MODE_FF_TO_DF:
            begin
                if (byte_val == cct_pkg::BYTE_FF)
                begin
                    seq.b0 = cct_pkg::BYTE_DF;
                end
            end
            cct_pkg::MODE_DEC_CP866:
            begin
                if (byte_val[7])
                begin
                    seq.b0 = cct_pkg::DEC_CP866[byte_val[6:0]];
                end
            end
            cct_pkg::MODE_FF_DOUBLE:
            begin
                if (byte_val == cct_pkg::BYTE_FF)
                begin
                    seq.b1       = cct_pkg::BYTE_FF;
                    seq.last_idx = 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- design/cct_emit.sv -----
`timescale 1ns / 1ps

module cct_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  cct_pkg::seq_t     seq,
    input  logic              seq_valid,
    output logic              take,
    cct_out_if.source         coded
);

    cct_pkg::seq_t seq_reg;
    logic          vld_reg;
    logic          vld_next;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    logic          at_last;

    assign at_last = (idx_reg == seq_reg.last_idx);
    assign take    = seq_valid && (!vld_reg || (coded.ready && at_last));

    always_comb
    begin
        vld_next = vld_reg;
        idx_next = idx_reg;
        if (take)
        begin
            vld_next = 1'b1;
            idx_next = 2'd0;
        end
        else if (vld_reg && coded.ready)
        begin
            if (at_last)
            begin
                vld_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seq_reg <= seq;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    coded.out_byte = seq_reg.b0;
            2'd1:    coded.out_byte = seq_reg.b1;
            default: coded.out_byte = seq_reg.b2;
        endcase
    end

    assign coded.valid       = vld_reg;
    assign coded.last_of_run = at_last;

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> idx_reg <= seq_reg.last_idx)
        else $error("byte index ran past the end of its run");

    a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && coded.ready && !at_last) |=> (vld_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("run did not advance to its next byte");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (vld_reg && idx_reg == 2'd0))
        else $error("new run did not start at its first byte");

    a_three_is_ch: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && seq_reg.last_idx == 2'd2) |-> seq_reg.b1 == cct_pkg::LETTER_C)
        else $error("three byte run that is not a ch suffix");
`endif

endmodule
